>>> design/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, codes and sizes of the deadlock-avoidance unit.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int MAX_RES     = 8;
  localparam int COUNT_WIDTH = 16;

  localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int AW    = PW + RW;
  localparam int DEPTH = MAX_PROCS * MAX_RES;

  // Configuration register widths
  localparam int NPW = 5;
  localparam int NRW = 4;

  // Commands
  localparam logic [2:0] CMD_LD_MAX   = 3'd0;
  localparam logic [2:0] CMD_LD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_LD_AVAIL = 3'd2;
  localparam logic [2:0] CMD_REQ      = 3'd3;
  localparam logic [2:0] CMD_CHECK    = 3'd4;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SAFE      = 4'd1;
  localparam logic [3:0] ST_UNSAFE    = 4'd2;
  localparam logic [3:0] ST_GRANTED   = 4'd3;
  localparam logic [3:0] ST_OVER_NEED = 4'd4;
  localparam logic [3:0] ST_OVER_AVL  = 4'd5;
  localparam logic [3:0] ST_DENIED    = 4'd6;
  localparam logic [3:0] ST_NOT_READY = 4'd7;
  localparam logic [3:0] ST_OVER_MAX  = 4'd8;
  localparam logic [3:0] ST_BAD_IDX   = 4'd9;

  // Register indexes
  localparam logic REG_NUM_PROCS = 1'b0;
  localparam logic REG_NUM_RES   = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_LD_EV,
    S_CK_RD, S_CK_EV, S_AP_RD, S_AP_EV,
    S_W_INIT, S_W_PROC, S_W_RD, S_W_EV,
    S_WA_RD, S_WA_EV, S_EMIT, S_STATUS
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  process_index;
    logic [2:0]  resource_index;
    logic [15:0] amount;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] process_id;
    logic [3:0] status;
    logic       final_res;
  } out_item_t;

endpackage

>>> design/bda_ram.sv
// ----------------------------------------------------------------------------
// bda_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bda_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/bankers_deadlock_avoidance.sv
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Banker's deadlock-avoidance unit: table loads, request checks with a
// safety walk and rollback, and safe-order reporting.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_stall, in_data (in_item_t) | items in
//  out     | out_valid, out_stall, out_data          | results out
//  config  | psel, penable, pwrite, paddr, pwdata,   | register access
//          | prdata, pready                          |
//
// After reset the unit zeroes all 128 entries of the demand and allocation
// memories, one entry a cycle, and takes no item meanwhile.
// A table load passes S_DISP, then S_LD_EV for the demand and allocation
// tables. A request checks and grants each resource in turn, then walks: up to
// np*(np+1)/2 process tests of nr reads each, every read with its own evaluate
// state, set by the single memory port. Each result passes the output register.
// One item is worked on at a time; a stalled result holds the sequencer.
module bankers_deadlock_avoidance
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [NPW-1:0]    np_r;
  logic [NRW-1:0]    nr_r;
  logic [NPW-1:0]    np_eff;
  logic [NRW-1:0]    nr_eff;
  logic [RW-1:0]     j_r, j_nxt;
  logic [PW-1:0]     i_r, i_nxt;
  logic [PW-1:0]     k_r, k_nxt;
  logic [PW:0]       done_r, done_nxt;
  logic              undo_r, undo_nxt;
  logic              ready_r, ready_nxt;
  logic [3:0]        status_r, status_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [COUNT_WIDTH-1:0] avail_r [MAX_RES];
  logic [COUNT_WIDTH-1:0] avail_nxt [MAX_RES];
  logic [COUNT_WIDTH-1:0] req_r [MAX_RES];
  logic [COUNT_WIDTH-1:0] req_nxt [MAX_RES];
  logic [COUNT_WIDTH-1:0] work_r [MAX_RES];
  logic [COUNT_WIDTH-1:0] work_nxt [MAX_RES];
  logic [MAX_PROCS-1:0]   fin_r, fin_nxt;
  logic [PW-1:0]          order_r [MAX_PROCS];
  logic [PW-1:0]          order_nxt [MAX_PROCS];
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [AW-1:0]          mem_addr;
  logic                   max_we, alloc_we;
  logic [COUNT_WIDTH-1:0] max_wd, alloc_wd, max_rd, alloc_rd;

  logic                   out_free, j_last, i_last, bad_idx, is_req, cfg_wr;
  logic [COUNT_WIDTH-1:0] need, req_j, amt;
  logic [COUNT_WIDTH:0]   wsum;
  logic [COUNT_WIDTH-1:0] wsat;

  bda_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_max_ram (
    .clk(clk), .we(max_we), .addr(mem_addr), .wdata(max_wd), .rdata(max_rd)
  );

  bda_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_alloc_ram (
    .clk(clk), .we(alloc_we), .addr(mem_addr), .wdata(alloc_wd), .rdata(alloc_rd)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NUM_PROCS) begin
      prdata = 32'(np_r);
    end else begin
      prdata = 32'(nr_r);
    end
  end

  assign np_eff = (np_r == '0) ? NPW'(1) :
                  ((np_r > NPW'(MAX_PROCS)) ? NPW'(MAX_PROCS) : np_r);
  assign nr_eff = (nr_r == '0) ? NRW'(1) :
                  ((nr_r > NRW'(MAX_RES)) ? NRW'(MAX_RES) : nr_r);

  // Shared conditions
  assign out_free = !out_valid_r || !out_stall;
  assign j_last   = (NRW'(j_r) == nr_eff - NRW'(1));
  assign i_last   = (NPW'(i_r) == np_eff - NPW'(1));
  assign bad_idx  = (NPW'(item_r.process_index) >= np_eff) ||
                    (NRW'(item_r.resource_index) >= nr_eff);
  assign is_req   = (item_r.command == CMD_REQ);
  assign amt      = COUNT_WIDTH'(item_r.amount);
  assign need     = max_rd - alloc_rd;
  assign req_j    = req_r[j_r];
  assign wsum     = {1'b0, work_r[j_r]} + {1'b0, alloc_rd};
  assign wsat     = wsum[COUNT_WIDTH] ? '1 : wsum[COUNT_WIDTH-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        priority if (item_r.command > CMD_CHECK) state_nxt = S_IDLE;
        else if (item_r.command == CMD_CHECK) begin
          state_nxt = ready_r ? S_W_INIT : S_STATUS;
        end else if (is_req && !ready_r) state_nxt = S_STATUS;
        else if (bad_idx) state_nxt = S_STATUS;
        else if (item_r.command == CMD_LD_MAX || item_r.command == CMD_LD_ALLOC) begin
          state_nxt = S_LD_EV;
        end else if (is_req && item_r.last) state_nxt = S_CK_RD;
        else state_nxt = S_STATUS;
      end
      S_LD_EV:  state_nxt = S_STATUS;
      S_CK_RD:  state_nxt = S_CK_EV;
      S_CK_EV: begin
        priority if (req_j > need || req_j > avail_r[j_r]) state_nxt = S_STATUS;
        else if (j_last) state_nxt = S_AP_RD;
        else state_nxt = S_CK_RD;
      end
      S_AP_RD:  state_nxt = S_AP_EV;
      S_AP_EV: begin
        priority if (!j_last) state_nxt = S_AP_RD;
        else if (undo_r) state_nxt = S_STATUS;
        else state_nxt = S_W_INIT;
      end
      S_W_INIT: state_nxt = S_W_PROC;
      S_W_PROC: begin
        priority if (!fin_r[i_r]) state_nxt = S_W_RD;
        else if (!i_last) state_nxt = S_W_PROC;
        else state_nxt = is_req ? S_AP_RD : S_STATUS;
      end
      S_W_RD:   state_nxt = S_W_EV;
      S_W_EV: begin
        priority if (need > work_r[j_r]) begin
          if (!i_last) state_nxt = S_W_PROC;
          else state_nxt = is_req ? S_AP_RD : S_STATUS;
        end else if (j_last) state_nxt = S_WA_RD;
        else state_nxt = S_W_RD;
      end
      S_WA_RD:  state_nxt = S_WA_EV;
      S_WA_EV: begin
        priority if (!j_last) state_nxt = S_WA_RD;
        else if (done_r == (PW+1)'(np_eff)) state_nxt = S_EMIT;
        else state_nxt = S_W_PROC;
      end
      S_EMIT: begin
        if (out_free && ((PW+1)'(k_r) + (PW+1)'(1) == done_r)) state_nxt = S_STATUS;
      end
      S_STATUS: if (out_free) state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_nxt      = item_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    done_nxt      = done_r;
    undo_nxt      = undo_r;
    ready_nxt     = ready_r;
    status_nxt    = status_r;
    clr_nxt       = clr_r;
    avail_nxt     = avail_r;
    req_nxt       = req_r;
    work_nxt      = work_r;
    fin_nxt       = fin_r;
    order_nxt     = order_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_addr      = {item_r.process_index[PW-1:0], item_r.resource_index[RW-1:0]};
    max_we        = 1'b0;
    alloc_we      = 1'b0;
    max_wd        = amt;
    alloc_wd      = amt;
    in_stall      = (state_r != S_IDLE);

    unique case (state_r)
      S_CLEAR: begin
        mem_addr = clr_r;
        max_we   = 1'b1;
        alloc_we = 1'b1;
        max_wd   = '0;
        alloc_wd = '0;
        clr_nxt  = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      S_DISP: begin
        status_nxt = ST_OK;
        j_nxt      = '0;
        undo_nxt   = 1'b0;
        priority if (item_r.command > CMD_CHECK) begin
          status_nxt = ST_OK;
        end else if (item_r.command == CMD_CHECK) begin
          if (!ready_r) status_nxt = ST_NOT_READY;
        end else if (is_req && !ready_r) begin
          status_nxt = ST_NOT_READY;
        end else if (bad_idx) begin
          status_nxt = ST_BAD_IDX;
        end else if (item_r.command == CMD_LD_AVAIL) begin
          avail_nxt[item_r.resource_index[RW-1:0]] = amt;
          if (item_r.last) ready_nxt = 1'b1;
        end else if (is_req) begin
          req_nxt[item_r.resource_index[RW-1:0]] = amt;
        end
      end
      S_LD_EV: begin
        if (item_r.command == CMD_LD_MAX) begin
          if (alloc_rd > amt) status_nxt = ST_OVER_MAX;
          else max_we = 1'b1;
        end else begin
          if (amt > max_rd) status_nxt = ST_OVER_MAX;
          else alloc_we = 1'b1;
        end
      end
      S_CK_RD, S_CK_EV, S_AP_RD, S_AP_EV: begin
        mem_addr = {item_r.process_index[PW-1:0], j_r};
        if (state_r == S_CK_EV) begin
          priority if (req_j > need) status_nxt = ST_OVER_NEED;
          else if (req_j > avail_r[j_r]) status_nxt = ST_OVER_AVL;
          else j_nxt = j_last ? '0 : j_r + RW'(1);
        end else if (state_r == S_AP_EV) begin
          alloc_we = 1'b1;
          if (undo_r) begin
            alloc_wd        = alloc_rd - req_j;
            avail_nxt[j_r]  = avail_r[j_r] + req_j;
            status_nxt      = ST_DENIED;
          end else begin
            alloc_wd        = alloc_rd + req_j;
            avail_nxt[j_r]  = avail_r[j_r] - req_j;
          end
          j_nxt = j_last ? '0 : j_r + RW'(1);
        end
      end
      S_W_INIT: begin
        work_nxt = avail_r;
        fin_nxt  = '0;
        i_nxt    = '0;
        j_nxt    = '0;
        done_nxt = '0;
      end
      S_W_PROC, S_W_RD, S_W_EV, S_WA_RD, S_WA_EV: begin
        mem_addr = {i_r, j_r};
        // A process that is finished or cannot finish moves the scan on; past the
        // last one the system is unsafe and a request is rolled back.
        if ((state_r == S_W_PROC && fin_r[i_r]) ||
            (state_r == S_W_EV && need > work_r[j_r])) begin
          if (!i_last) begin
            i_nxt = i_r + PW'(1);
          end else if (is_req) begin
            undo_nxt = 1'b1;
            j_nxt    = '0;
          end else begin
            status_nxt = ST_UNSAFE;
          end
        end else if (state_r == S_W_PROC) begin
          j_nxt = '0;
        end else if (state_r == S_W_EV) begin
          if (j_last) begin
            fin_nxt[i_r]                 = 1'b1;
            order_nxt[done_r[PW-1:0]]    = i_r;
            done_nxt                     = done_r + (PW+1)'(1);
            j_nxt                        = '0;
          end else begin
            j_nxt = j_r + RW'(1);
          end
        end else if (state_r == S_WA_EV) begin
          work_nxt[j_r] = wsat;
          if (!j_last) begin
            j_nxt = j_r + RW'(1);
          end else begin
            j_nxt      = '0;
            i_nxt      = '0;
            k_nxt      = '0;
            status_nxt = is_req ? ST_GRANTED : ST_SAFE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = 1'b0;
          out_data_nxt.process_id = 4'(order_r[k_r]);
          out_data_nxt.status     = ST_OK;
          out_data_nxt.final_res  = 1'b0;
          k_nxt                   = k_r + PW'(1);
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = 1'b1;
          out_data_nxt.process_id = '0;
          out_data_nxt.status     = status_r;
          out_data_nxt.final_res  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      fin_r       <= '0;
      np_r        <= NPW'(16);
      nr_r        <= NRW'(8);
      for (int n = 0; n < MAX_RES; n++) begin
        avail_r[n] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      fin_r       <= fin_nxt;
      avail_r     <= avail_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_NUM_PROCS) np_r <= pwdata[NPW-1:0];
        else nr_r <= pwdata[NRW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    done_r     <= done_nxt;
    undo_r     <= undo_nxt;
    status_r   <= status_nxt;
    req_r      <= req_nxt;
    work_r     <= work_nxt;
    order_r    <= order_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_alloc_within_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_EV && alloc_we) |-> (alloc_wd <= max_rd))
    else $error("allocation load written above maximum demand");

  a_done_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR && state_r != S_IDLE) |-> (done_r <= (PW+1)'(MAX_PROCS)))
    else $error("safe order count past process table depth");

  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(ready_r))
    else $error("setup flag cleared without reset");

  a_order_entry_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.kind) |-> (out_data.status == ST_OK && !out_data.final_res))
    else $error("safe order entry carries a status or final flag");
`endif

endmodule
